### src/rbap_pkg.sv
// shared constants, codes and types of the bulk/array request parser
// no dependencies; imported by every module and interface of the block
package rbap_pkg;

   localparam int LENGTH_BITS   = 32;
   localparam int ACC_WIDE_BITS = LENGTH_BITS + 4;
   localparam int CFG_BITS      = 31;
   localparam int ELEM_BITS     = 31;
   localparam int CMP_BITS      = (LENGTH_BITS > CFG_BITS) ? LENGTH_BITS : CFG_BITS;
   localparam int BYTE_BITS     = 8;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [LENGTH_BITS-1:0] LEN_CAP = {1'b1, {(LENGTH_BITS-1){1'b0}}};

   localparam logic [CFG_BITS-1:0] MAX_BULK_RESET  = CFG_BITS'(536870912);
   localparam logic [CFG_BITS-1:0] MAX_ARRAY_RESET = CFG_BITS'(1048576);

   localparam logic [BYTE_BITS-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_LF     = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_BITS-1:0] CHAR_STAR   = 8'h2A;
   localparam logic [BYTE_BITS-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [BYTE_BITS-1:0] CHAR_PLUS   = 8'h2B;
   localparam logic [BYTE_BITS-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_NINE   = 8'h39;

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_HFIRST,
      PH_HBODY,
      PH_HLF,
      PH_PAYLOAD,
      PH_TRAIL1,
      PH_TRAIL2
   } phase_type;

   typedef enum logic [1:0] {
      RT_PAYLOAD,
      RT_EMPTY,
      RT_NULL,
      RT_ERROR
   } result_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_UNKNOWN_TYPE,
      ERR_BAD_LENGTH,
      ERR_NON_BULK,
      ERR_OVER_LIMIT
   } error_kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MAX_BULK,
      CSR_MAX_ARRAY
   } csr_index_type;

   typedef struct packed {
      logic [1:0]           result_type;
      logic [BYTE_BITS-1:0] payload_byte;
      logic                 last_of_string;
      logic                 last_of_message;
      logic [2:0]           error_code;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } step_result_type;

endpackage

### src/rbap_channels.sv
// valid/ready channel interfaces for request bytes and parser results
// depends on rbap_pkg
interface rbap_req_if import rbap_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface rbap_rsp_if import rbap_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           result_type;
   logic [BYTE_BITS-1:0] payload_byte;
   logic                 last_of_string;
   logic                 last_of_message;
   logic [2:0]           error_code;

   modport source (output valid, output result_type, output payload_byte,
                   output last_of_string, output last_of_message, output error_code,
                   input ready);
   modport sink (input valid, input result_type, input payload_byte,
                 input last_of_string, input last_of_message, input error_code,
                 output ready);
endinterface

### src/rbap_in_stage.sv
// input register of the parser: holds one request byte until the core takes it
// depends on rbap_pkg and rbap_req_if
module rbap_in_stage import rbap_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   rbap_req_if.sink             req_chan,
   input  logic                 advance,
   output logic                 byte_valid,
   output logic [BYTE_BITS-1:0] byte_data
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [BYTE_BITS-1:0] byte_ff;
   logic                 accept;

   assign req_chan.ready = !valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_chan.data_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

### src/rbap_core.sv
// parser state machine, length decoder and limit registers
// depends on rbap_pkg
module rbap_core import rbap_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_write_data,
   input  logic                    step_en,
   input  logic [BYTE_BITS-1:0]    data_byte,
   output step_result_type         result
);

   logic [CFG_BITS-1:0]    max_bulk_ff;
   logic [CFG_BITS-1:0]    max_array_ff;

   phase_type              phase_ff, phase_in;
   logic                   header_is_array_ff, header_is_array_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic                   negative_ff, negative_in;
   logic                   digit_seen_ff, digit_seen_in;
   logic                   digits_ended_ff, digits_ended_in;
   logic [ELEM_BITS-1:0]   payload_rem_ff, payload_rem_in;
   logic [ELEM_BITS-1:0]   elems_rem_ff, elems_rem_in;
   logic                   inside_array_ff, inside_array_in;

   // byte and header decode
   logic                     is_digit, is_cr, is_lf;
   logic [3:0]               digit_val;
   logic [ACC_WIDE_BITS-1:0] acc_wide;
   logic [LENGTH_BITS-1:0]   acc_digit;
   logic                     len_zero, len_one, neg_nonzero, null_len;
   logic                     hdr_bad, array_quiet, hdr_over, hdr_fail;
   logic [CMP_BITS-1:0]      len_cmp;
   logic [ELEM_BITS-1:0]     len_elem;
   error_kind_type           hdr_err;
   logic [ELEM_BITS-1:0]     elems_dec;
   logic                     hdr_lom;
   logic [ELEM_BITS-1:0]     payload_dec;
   logic                     payload_last;
   logic                     cur_msg_end;
   logic                     type_ok;
   error_kind_type           type_err;
   logic                     clear_all;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bulk_ff  <= MAX_BULK_RESET;
         max_array_ff <= MAX_ARRAY_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MAX_BULK:  max_bulk_ff  <= csr_write_data;
            CSR_MAX_ARRAY: max_array_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
      is_cr     = (data_byte == CHAR_CR);
      is_lf     = (data_byte == CHAR_LF);
      digit_val = 4'(data_byte - CHAR_ZERO);
      // length * 10 + digit, saturating at the cap
      acc_wide  = (ACC_WIDE_BITS'(length_ff) << 3) + (ACC_WIDE_BITS'(length_ff) << 1)
                + ACC_WIDE_BITS'(digit_val);
      acc_digit = (acc_wide > ACC_WIDE_BITS'(LEN_CAP)) ? LEN_CAP : LENGTH_BITS'(acc_wide);

      len_zero    = (length_ff == '0);
      len_one     = (length_ff == LENGTH_BITS'(1));
      neg_nonzero = negative_ff && !len_zero;
      null_len    = neg_nonzero && len_one;
      hdr_bad     = !digit_seen_ff || (length_ff >= LEN_CAP) || (neg_nonzero && !len_one);
      len_cmp     = CMP_BITS'(length_ff);
      len_elem    = ELEM_BITS'(len_cmp);
      array_quiet = header_is_array_ff && (null_len || len_zero);
      hdr_over    = header_is_array_ff ? (len_cmp > CMP_BITS'(max_array_ff))
                                       : (!null_len && (len_cmp > CMP_BITS'(max_bulk_ff)));
      hdr_fail    = hdr_bad || (!array_quiet && hdr_over);
      hdr_err     = hdr_bad ? ERR_BAD_LENGTH : ERR_OVER_LIMIT;

      elems_dec   = (inside_array_ff && (elems_rem_ff != '0)) ? elems_rem_ff - ELEM_BITS'(1)
                                                              : elems_rem_ff;
      hdr_lom     = !inside_array_ff || (elems_dec == '0);
      payload_dec = payload_rem_ff - ELEM_BITS'(1);
      payload_last = (payload_dec == '0);
      cur_msg_end = !inside_array_ff || (elems_rem_ff == '0);

      type_ok  = inside_array_ff ? (data_byte == CHAR_DOLLAR)
                                 : ((data_byte == CHAR_DOLLAR) || (data_byte == CHAR_STAR));
      type_err = inside_array_ff ? ERR_NON_BULK : ERR_UNKNOWN_TYPE;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HFIRST: begin
            phase_in = is_cr ? PH_HLF : PH_HBODY;
         end
         PH_HBODY: begin
            if (is_cr) begin
               phase_in = PH_HLF;
            end
         end
         PH_HLF: begin
            if (is_lf) begin
               if (hdr_fail || header_is_array_ff || null_len) begin
                  phase_in = PH_TYPE;
               end else if (len_zero) begin
                  phase_in = PH_TRAIL1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end else if (!is_cr) begin
               phase_in = PH_HBODY;
            end
         end
         PH_PAYLOAD: begin
            if (payload_last) begin
               phase_in = PH_TRAIL1;
            end
         end
         PH_TRAIL1: phase_in = PH_TRAIL2;
         PH_TRAIL2: phase_in = PH_TYPE;
         default: begin
            phase_in = type_ok ? PH_HFIRST : PH_TYPE;
         end
      endcase
   end

   // datapath state and result
   always_comb begin
      header_is_array_in = header_is_array_ff;
      length_in          = length_ff;
      negative_in        = negative_ff;
      digit_seen_in      = digit_seen_ff;
      digits_ended_in    = digits_ended_ff;
      payload_rem_in     = payload_rem_ff;
      elems_rem_in       = elems_rem_ff;
      inside_array_in    = inside_array_ff;
      clear_all          = 1'b0;
      result             = '0;

      unique case (phase_ff)
         PH_HFIRST: begin
            if (data_byte == CHAR_MINUS) begin
               negative_in = 1'b1;
            end else if (data_byte == CHAR_PLUS) begin
               negative_in = negative_ff;
            end else if (is_digit) begin
               length_in     = acc_digit;
               digit_seen_in = 1'b1;
            end else if (!is_cr) begin
               digits_ended_in = 1'b1;
            end
         end
         PH_HBODY: begin
            if (!is_cr) begin
               if (is_digit && !digits_ended_ff) begin
                  length_in     = acc_digit;
                  digit_seen_in = 1'b1;
               end else begin
                  digits_ended_in = 1'b1;
               end
            end
         end
         PH_HLF: begin
            if (!is_lf) begin
               // lone cr in the header ends the digits
               digits_ended_in = 1'b1;
            end else if (hdr_fail) begin
               clear_all                = 1'b1;
               result.valid             = 1'b1;
               result.item.result_type  = RT_ERROR;
               result.item.error_code   = hdr_err;
            end else if (header_is_array_ff) begin
               if (array_quiet) begin
                  clear_all = 1'b1;
               end else begin
                  inside_array_in = 1'b1;
                  elems_rem_in    = len_elem;
               end
            end else begin
               elems_rem_in = elems_dec;
               if (null_len) begin
                  if (hdr_lom) begin
                     inside_array_in = 1'b0;
                  end
                  result.valid                = 1'b1;
                  result.item.result_type     = RT_NULL;
                  result.item.last_of_string  = 1'b1;
                  result.item.last_of_message = hdr_lom;
               end else if (len_zero) begin
                  result.valid                = 1'b1;
                  result.item.result_type     = RT_EMPTY;
                  result.item.last_of_string  = 1'b1;
                  result.item.last_of_message = hdr_lom;
               end else begin
                  payload_rem_in = len_elem;
               end
            end
         end
         PH_PAYLOAD: begin
            payload_rem_in              = payload_dec;
            result.valid                = 1'b1;
            result.item.result_type     = RT_PAYLOAD;
            result.item.payload_byte    = data_byte;
            result.item.last_of_string  = payload_last;
            result.item.last_of_message = payload_last && cur_msg_end;
         end
         PH_TRAIL1: begin
            clear_all = 1'b0;
         end
         PH_TRAIL2: begin
            if (cur_msg_end) begin
               inside_array_in = 1'b0;
            end
         end
         default: begin
            if (!type_ok) begin
               clear_all               = 1'b1;
               result.valid            = 1'b1;
               result.item.result_type = RT_ERROR;
               result.item.error_code  = type_err;
            end else begin
               header_is_array_in = (data_byte == CHAR_STAR);
               length_in          = '0;
               negative_in        = 1'b0;
               digit_seen_in      = 1'b0;
               digits_ended_in    = 1'b0;
            end
         end
      endcase

      if (clear_all) begin
         header_is_array_in = 1'b0;
         length_in          = '0;
         negative_in        = 1'b0;
         digit_seen_in      = 1'b0;
         digits_ended_in    = 1'b0;
         payload_rem_in     = '0;
         elems_rem_in       = '0;
         inside_array_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_TYPE;
         header_is_array_ff <= 1'b0;
         length_ff          <= '0;
         negative_ff        <= 1'b0;
         digit_seen_ff      <= 1'b0;
         digits_ended_ff    <= 1'b0;
         payload_rem_ff     <= '0;
         elems_rem_ff       <= '0;
         inside_array_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff           <= phase_in;
         header_is_array_ff <= header_is_array_in;
         length_ff          <= length_in;
         negative_ff        <= negative_in;
         digit_seen_ff      <= digit_seen_in;
         digits_ended_ff    <= digits_ended_in;
         payload_rem_ff     <= payload_rem_in;
         elems_rem_ff       <= elems_rem_in;
         inside_array_ff    <= inside_array_in;
      end
   end

endmodule

### src/rbap_out_stage.sv
// result register of the parser, drives the result channel
// depends on rbap_pkg and rbap_rsp_if
module rbap_out_stage import rbap_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type item,
   output logic         can_take,
   rbap_rsp_if.source   rsp_chan
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign can_take = !valid_ff || rsp_chan.ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.result_type     = item_ff.result_type;
   assign rsp_chan.payload_byte    = item_ff.payload_byte;
   assign rsp_chan.last_of_string  = item_ff.last_of_string;
   assign rsp_chan.last_of_message = item_ff.last_of_message;
   assign rsp_chan.error_code      = item_ff.error_code;

endmodule

### src/resp_bulk_array_parser.sv
// top level of the bulk string / array request parser
// depends on rbap_pkg, rbap_channels, rbap_in_stage, rbap_core, rbap_out_stage
//
// usage
//  - req_chan carries the raw request stream, one byte per transaction
//  - rsp_chan carries at most one result per byte: a payload byte, an empty
//    or null string marker, or an error with its code
//  - csr_write_en / csr_index / csr_write_data set the bulk length limit
//    (index 0) and the array count limit (index 1); write only while idle
//  - a byte lands in the input register; when the result register has room,
//    the state machine updates and loads any result into the result register
//  - throughput: one byte per cycle unless rsp_chan stalls, set by the single
//    state update per byte
//  - bytes that finish nothing (headers, trailers) give no transaction
//  - when rsp_chan stalls, one more byte is still taken into the input
//    register, then req_chan.ready drops until the result register drains
//  - reset (synchronous) empties both registers, returns the parser to
//    expecting a type byte and restores the default limits
module resp_bulk_array_parser import rbap_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   rbap_req_if.sink                req_chan,
   rbap_rsp_if.source              rsp_chan,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_write_data
);

   logic                 byte_valid;
   logic [BYTE_BITS-1:0] byte_data;
   logic                 can_take;
   logic                 advance;
   step_result_type      step_result;

   // a byte is processed when the result register has room
   assign advance = byte_valid && can_take;

   rbap_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   rbap_core u_core (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .step_en        (advance),
      .data_byte      (byte_data),
      .result         (step_result)
   );

   // only bytes that complete something load the result register
   rbap_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && step_result.valid),
      .item     (step_result.item),
      .can_take (can_take),
      .rsp_chan (rsp_chan)
   );

endmodule

### tb/sv/rbap_scoreboard_pkg.sv
`timescale 1ns / 1ps
// scoreboard class of the bulk/array request parser test: predicts the results
// byte by byte and checks what the block delivers; depends on rbap_pkg
package rbap_scoreboard_pkg;
   import rbap_pkg::*;

   class resp_result_scoreboard;
      logic [CFG_BITS-1:0]    bulk_limit;
      logic [CFG_BITS-1:0]    count_limit;
      phase_type              phase;
      bit                     is_array;
      bit                     negative;
      bit                     have_digit;
      bit                     digits_done;
      bit                     in_array;
      logic [LENGTH_BITS-1:0] length;
      logic [ELEM_BITS-1:0]   bytes_left;
      logic [ELEM_BITS-1:0]   elems_left;
      rsp_item_type           pending_results[$];
      int                     mismatches;

      function new();
         bulk_limit = MAX_BULK_RESET;
         count_limit = MAX_ARRAY_RESET;
         mismatches = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         phase = PH_TYPE;
         is_array = 0;
         negative = 0;
         have_digit = 0;
         digits_done = 0;
         in_array = 0;
         length = '0;
         bytes_left = '0;
         elems_left = '0;
      endfunction

      function void set_limit(csr_index_type idx, logic [CFG_BITS-1:0] value);
         if (idx == CSR_MAX_BULK) begin
            bulk_limit = value;
         end else begin
            count_limit = value;
         end
      endfunction

      function void queue_result(result_kind_type kind, logic [BYTE_BITS-1:0] data, bit los,
                                 bit lom, error_kind_type err);
         rsp_item_type r;
         r.result_type = kind;
         r.payload_byte = data;
         r.last_of_string = los;
         r.last_of_message = lom;
         r.error_code = err;
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void parse_error(error_kind_type err);
         clear_parse();
         queue_result(RT_ERROR, '0, 0, 0, err);
      endfunction

      // saturating decimal accumulate
      function void add_digit(logic [BYTE_BITS-1:0] b);
         logic [ACC_WIDE_BITS-1:0] v;
         v = ACC_WIDE_BITS'(length) * 10 + ACC_WIDE_BITS'(b - CHAR_ZERO);
         length = (v > LEN_CAP) ? LEN_CAP : v[LENGTH_BITS-1:0];
         have_digit = 1;
      endfunction

      function bit message_ends();
         return !in_array || elems_left == 0;
      endfunction

      function void string_done();
         if (message_ends())
            in_array = 0;
         phase = PH_TYPE;
      endfunction

      function void header_done();
         bit is_null;
         bit lom;
         is_null = 0;
         if (!have_digit || length >= LEN_CAP) begin
            parse_error(ERR_BAD_LENGTH);
            return;
         end
         if (negative && length != 0) begin
            if (length != 1) begin
               parse_error(ERR_BAD_LENGTH);
               return;
            end
            is_null = 1;
         end
         if (is_array) begin
            // null array and zero count give nothing
            if (is_null || length == 0) begin
               clear_parse();
               return;
            end
            if (length > count_limit) begin
               parse_error(ERR_OVER_LIMIT);
               return;
            end
            in_array = 1;
            elems_left = length[ELEM_BITS-1:0];
            phase = PH_TYPE;
            return;
         end
         if (!is_null && length > bulk_limit) begin
            parse_error(ERR_OVER_LIMIT);
            return;
         end
         if (in_array && elems_left > 0)
            elems_left = elems_left - 1'b1;
         if (is_null) begin
            lom = message_ends();
            string_done();
            queue_result(RT_NULL, '0, 1, lom, ERR_NONE);
            return;
         end
         if (length == 0) begin
            phase = PH_TRAIL1;
            queue_result(RT_EMPTY, '0, 1, message_ends(), ERR_NONE);
            return;
         end
         bytes_left = length[ELEM_BITS-1:0];
         phase = PH_PAYLOAD;
      endfunction

      function void note_request_byte(logic [BYTE_BITS-1:0] b);
         bit digit;
         bit los;
         bit lom;
         digit = (b >= CHAR_ZERO && b <= CHAR_NINE);
         case (phase)
            PH_HFIRST: begin
               if (b == CHAR_MINUS) begin
                  negative = 1;
                  phase = PH_HBODY;
               end else if (b == CHAR_PLUS) begin
                  phase = PH_HBODY;
               end else if (digit) begin
                  add_digit(b);
                  phase = PH_HBODY;
               end else if (b == CHAR_CR) begin
                  phase = PH_HLF;
               end else begin
                  digits_done = 1;
                  phase = PH_HBODY;
               end
            end
            PH_HBODY: begin
               if (b == CHAR_CR)
                  phase = PH_HLF;
               else if (digit && !digits_done)
                  add_digit(b);
               else
                  digits_done = 1;
            end
            PH_HLF: begin
               if (b == CHAR_LF) begin
                  header_done();
               end else begin
                  digits_done = 1;
                  if (b != CHAR_CR)
                     phase = PH_HBODY;
               end
            end
            PH_PAYLOAD: begin
               bytes_left = bytes_left - 1'b1;
               los = (bytes_left == 0);
               lom = 0;
               if (los) begin
                  lom = message_ends();
                  phase = PH_TRAIL1;
               end
               queue_result(RT_PAYLOAD, b, los, lom, ERR_NONE);
            end
            PH_TRAIL1: phase = PH_TRAIL2;
            PH_TRAIL2: string_done();
            default: begin
               if (in_array) begin
                  if (b != CHAR_DOLLAR) begin
                     parse_error(ERR_NON_BULK);
                     return;
                  end
               end else if (b != CHAR_DOLLAR && b != CHAR_STAR) begin
                  parse_error(ERR_UNKNOWN_TYPE);
                  return;
               end
               is_array = (b == CHAR_STAR);
               length = '0;
               negative = 0;
               have_digit = 0;
               digits_done = 0;
               phase = PH_HFIRST;
            end
         endcase
      endfunction

      function void report(string what, rsp_item_type want, rsp_item_type got);
         string want_txt;
         string got_txt;
         mismatches++;
         if (mismatches <= 10) begin
            want_txt = $sformatf("type %0d byte %02h los %0b lom %0b err %0d",
                                 want.result_type, want.payload_byte, want.last_of_string,
                                 want.last_of_message, want.error_code);
            got_txt = $sformatf("type %0d byte %02h los %0b lom %0b err %0d",
                                got.result_type, got.payload_byte, got.last_of_string,
                                got.last_of_message, got.error_code);
            $display("%0t mismatch (%s): expected %s, got %s", $time, what, want_txt,
                     got_txt);
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         string diffs;
         if (pending_results.size() == 0) begin
            report("no result pending", '0, got);
            return;
         end
         want = pending_results.pop_front();
         diffs = "";
         if (got.result_type != want.result_type)
            diffs = {diffs, " result_type"};
         if (got.payload_byte != want.payload_byte)
            diffs = {diffs, " payload_byte"};
         if (got.last_of_string != want.last_of_string)
            diffs = {diffs, " last_of_string"};
         if (got.last_of_message != want.last_of_message)
            diffs = {diffs, " last_of_message"};
         if (got.error_code != want.error_code)
            diffs = {diffs, " error_code"};
         if (diffs != "")
            report({"field", diffs}, want, got);
      endfunction
   endclass

endpackage

### tb/sv/resp_bulk_array_parser_test.sv
`timescale 1ns / 1ps
// top of the bulk/array request parser test: drives byte streams and limit writes,
// checks every result; depends on rbap_pkg, rbap_channels, rbap_scoreboard_pkg and resp_bulk_array_parser
module resp_bulk_array_parser_test;
   import rbap_pkg::*;
   import rbap_scoreboard_pkg::*;

   localparam int PHASE_BYTES = 140;     // request bytes per limit setting
   localparam int HOLD_CYCLES = 300;     // long receiver hold-off
   localparam int SETTLE_CYCLES = 4;     // covers the two-register latency
   localparam longint RUN_LIMIT_NS = 10_000_000;

   logic clock;
   logic reset;
   logic                    csr_write_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]     csr_write_data;

   rbap_req_if req_if ();
   rbap_rsp_if rsp_if ();

   resp_result_scoreboard sb;
   rsp_item_type          seen;
   logic [BYTE_BITS-1:0]  stream_q[$];   // bytes of the message under construction
   bit                    calm;          // no idling on either side
   bit                    hold_request;  // asks the receiver for a long hold-off

   resp_bulk_array_parser i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

   // monitor: both channels sampled at the edge, request side first
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_request_byte(req_if.data_byte);
         if (rsp_if.valid && rsp_if.ready) begin
            seen = {rsp_if.result_type, rsp_if.payload_byte, rsp_if.last_of_string,
                    rsp_if.last_of_message, rsp_if.error_code};
            sb.check_result(seen);
         end
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // receiver: random stalls, plus a counted long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 0;
            rsp_if.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
               stall_left = pick_gap();
         end
      end
   end

   // one request transaction, then maybe an idle gap
   task automatic send_byte(logic [BYTE_BITS-1:0] b);
      int gap;
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_stream();
      foreach (stream_q[i])
         send_byte(stream_q[i]);
      stream_q.delete();
   endtask

   // stop offering bytes and wait until every predicted result has arrived
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both limit registers, back to back; only called while idle
   task automatic write_limits(logic [CFG_BITS-1:0] bulk, logic [CFG_BITS-1:0] count);
      csr_write_en <= 1'b1;
      csr_index <= CSR_MAX_BULK;
      csr_write_data <= bulk;
      @(posedge clock);
      sb.set_limit(CSR_MAX_BULK, bulk);
      csr_index <= CSR_MAX_ARRAY;
      csr_write_data <= count;
      @(posedge clock);
      sb.set_limit(CSR_MAX_ARRAY, count);
      csr_write_en <= 1'b0;
   endtask

   // append one byte to the message under construction
   task automatic add_byte(logic [BYTE_BITS-1:0] b);
      stream_q.insert(stream_q.size(), b);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endtask

   task automatic add_crlf();
      add_byte(CHAR_CR);
      add_byte(CHAR_LF);
   endtask

   task automatic add_header(logic [BYTE_BITS-1:0] kind, string len_text);
      add_byte(kind);
      add_text(len_text);
      add_crlf();
   endtask

   // protocol characters favored; digits only where a long length gets rejected
   function automatic logic [BYTE_BITS-1:0] noise_byte();
      logic [BYTE_BITS-1:0] b;
      case ($urandom_range(0, 9))
         0: b = CHAR_DOLLAR;
         1: b = CHAR_STAR;
         2: b = CHAR_CR;
         3: b = CHAR_LF;
         4: b = CHAR_MINUS;
         5: b = CHAR_PLUS;
         6: b = 8'h20;
         default: b = BYTE_BITS'($urandom);
      endcase
      if (sb.bulk_limit > 64 && b >= CHAR_ZERO && b <= CHAR_NINE)
         b = 8'h78;
      return b;
   endfunction

   // one bulk string: header variants, then payload and trailer where accepted
   task automatic add_bulk();
      int r;
      int len;
      int body;
      string txt;
      r = $urandom_range(0, 99);
      body = -1;
      if (r < 10) begin
         txt = "0";
         body = 0;
      end else if (r < 18) begin
         txt = "-1";
      end else if (r < 21) begin
         txt = "-0";
         body = 0;
      end else if (r < 24) begin
         txt = $sformatf("-%0d", $urandom_range(2, 9));
      end else if (r < 27) begin
         txt = ($urandom_range(0, 1) == 0) ? "" : " 4";
      end else begin
         if (sb.bulk_limit <= 40 && $urandom_range(0, 4) == 0)
            len = int'(sb.bulk_limit) + $urandom_range(0, 1);
         else if ($urandom_range(0, 9) == 0)
            len = $urandom_range(13, 40);
         else
            len = $urandom_range(1, 12);
         if (len <= int'(sb.bulk_limit))
            body = len;
         case ($urandom_range(0, 11))
            0: txt = $sformatf("+%0d", len);
            1: txt = $sformatf("%0d x", len);
            2: txt = $sformatf("00%0d", len);
            default: txt = $sformatf("%0d", len);
         endcase
      end
      add_header(CHAR_DOLLAR, txt);
      if (body >= 0) begin
         repeat (body) add_byte(BYTE_BITS'($urandom));
         // trailer content is skipped, so junk there is legal
         if ($urandom_range(0, 9) == 0) begin
            add_byte(BYTE_BITS'($urandom));
            add_byte(BYTE_BITS'($urandom));
         end else begin
            add_crlf();
         end
      end
   endtask

   task automatic add_array();
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = 0;
      if (r < 8) begin
         add_header(CHAR_STAR, "-1");
      end else if (r < 14) begin
         add_header(CHAR_STAR, "0");
      end else begin
         if (sb.count_limit <= 6 && $urandom_range(0, 2) == 0)
            n = int'(sb.count_limit) + $urandom_range(0, 1);
         else
            n = $urandom_range(1, 4);
         add_header(CHAR_STAR, $sformatf("%0d", n));
      end
      repeat (n) add_bulk();
   endtask

   // mostly well-formed messages, the rest noise and broken messages
   task automatic add_random_message();
      int r;
      int cut;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         add_bulk();
      end else if (r < 78) begin
         add_array();
      end else if (r < 88) begin
         repeat ($urandom_range(1, 6)) add_byte(noise_byte());
      end else begin
         if ($urandom_range(0, 1) == 0)
            add_bulk();
         else
            add_array();
         cut = $urandom_range(0, stream_q.size() - 1);
         if ($urandom_range(0, 1) == 0) begin
            while (stream_q.size() > cut)
               void'(stream_q.pop_back());
         end else begin
            stream_q[cut] = noise_byte();
         end
      end
   endtask

   initial begin
      int sent;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_MAX_BULK;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      calm = 0;
      hold_request = 0;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the default limits
      add_header(CHAR_DOLLAR, "3");
      add_text("abc");
      add_crlf();
      add_header(CHAR_DOLLAR, "0");          // empty string eats its trailer
      add_crlf();
      add_header(CHAR_DOLLAR, "-1");         // null string
      add_header(CHAR_DOLLAR, "-0");         // minus zero is empty
      add_crlf();
      add_header(CHAR_DOLLAR, "+2");
      add_text("hi");
      add_crlf();
      add_header(CHAR_DOLLAR, "2 junk");     // rest of header ignored
      add_text("ok");
      add_crlf();
      // array mixing payload extremes, null and empty elements
      add_header(CHAR_STAR, "3");
      add_header(CHAR_DOLLAR, "2");
      add_byte(8'h00);
      add_byte(8'hFF);
      add_crlf();
      add_header(CHAR_DOLLAR, "-1");
      add_header(CHAR_DOLLAR, "0");
      add_crlf();
      add_header(CHAR_STAR, "-1");           // null array, silent
      add_header(CHAR_STAR, "0");            // zero count, silent
      add_text("!");                         // unknown type
      add_byte(8'h00);
      add_byte(8'hFF);
      add_header(CHAR_STAR, "2");
      add_text(":");                         // non-bulk element
      add_header(CHAR_STAR, "1");
      add_header(CHAR_STAR, "1");            // nested array is non-bulk too
      add_header(CHAR_DOLLAR, "");           // no digits
      add_header(CHAR_DOLLAR, " 5");         // leading space kills the digits
      add_header(CHAR_DOLLAR, "--1");        // second sign
      add_header(CHAR_DOLLAR, "-2");         // negative other than -1
      add_text("$4\0155\015\n");             // lone cr ends the digits: length 4
      add_text("wxyz");
      add_crlf();
      add_text("$1\015\015\n");              // cr cr lf
      add_text("Q");
      add_text("xy");                        // junk trailer
      add_header(CHAR_DOLLAR, "99999999999");  // saturates
      add_header(CHAR_DOLLAR, "2147483648");   // exactly the cap
      add_header(CHAR_DOLLAR, "536870913");    // above the bulk limit
      add_header(CHAR_STAR, "1048577");        // above the count limit
      send_stream();

      // random part, one limit setting per phase
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         case (ph)
            1: write_limits('0, '0);
            2: write_limits(CFG_BITS'(1), CFG_BITS'(1));
            3: begin
               write_limits(CFG_BITS'($urandom_range(2, 16)), CFG_BITS'($urandom_range(2, 5)));
               // receiver blocks while the sender keeps offering bytes
               hold_request = 1;
            end
            4: write_limits({CFG_BITS{1'b1}}, {CFG_BITS{1'b1}});
            5: begin
               write_limits(CFG_BITS'(12), CFG_BITS'(4));
               calm = 1;
            end
            6: begin
               calm = 0;
               write_limits(CFG_BITS'($urandom_range(0, 40)), CFG_BITS'($urandom_range(0, 6)));
            end
            7: write_limits(MAX_BULK_RESET, MAX_ARRAY_RESET);
            default: ;
         endcase
         sent = 0;
         while (sent < PHASE_BYTES) begin
            add_random_message();
            sent += stream_q.size();
            send_stream();
         end
      end

      drain();
      if (sb.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### files.f
src/rbap_pkg.sv
src/rbap_channels.sv
src/rbap_in_stage.sv
src/rbap_core.sv
src/rbap_out_stage.sv
src/resp_bulk_array_parser.sv
tb/sv/rbap_scoreboard_pkg.sv
tb/sv/resp_bulk_array_parser_test.sv
